>>> design/sbc_pkg.sv
package sbc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 48;
  localparam int CLEAR_W        = 18;
  localparam logic [CLEAR_W-1:0] CLEAR_MAX = '1;

  typedef enum logic [2:0] {
    OP_PT_BALL       = 3'd0,
    OP_BALL_BALL     = 3'd1,
    OP_BALL_BOX      = 3'd2,
    OP_PT_BOX        = 3'd3,
    OP_BOX_BOX       = 3'd4,
    OP_PT_BOX_DIST   = 3'd5,
    OP_BOX_BOX_DIST  = 3'd6
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic [FIELD_W-1:0] a_position;
    logic [FIELD_W-1:0] a_extent;
    logic [FIELD_W-1:0] b_position;
    logic [FIELD_W-1:0] b_extent;
  } in_item_t;

  typedef struct packed {
    logic               collided;
    logic [CLEAR_W-1:0] clearance;
  } out_item_t;

endpackage

>>> design/sbc_isqrt.sv
module sbc_isqrt #(
  parameter int VAL_W  = 34,
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [VAL_W-1:0]           in_value,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [(VAL_W+1)/2-1:0]     out_root,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int ROOT_W = (VAL_W + 1) / 2;

  logic              valid_r [ROOT_W];
  logic [VAL_W-1:0]  x_r     [ROOT_W];
  logic [ROOT_W-1:0] q_r     [ROOT_W];
  logic [SIDE_W-1:0] side_r  [ROOT_W];

  // One root bit per stage, most significant first; x holds value minus root squared.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int I = ROOT_W - 1 - j;
    logic              v_in;
    logic [VAL_W-1:0]  x_in;
    logic [VAL_W-1:0]  t;
    logic [ROOT_W-1:0] q_in;
    logic [SIDE_W-1:0] s_in;

    if (j == 0) begin : g_first
      assign v_in = in_valid;
      assign x_in = in_value;
      assign q_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = valid_r[j-1];
      assign x_in = x_r[j-1];
      assign q_in = q_r[j-1];
      assign s_in = side_r[j-1];
    end

    assign t = (VAL_W'(q_in) << (I + 1)) | (VAL_W'(1) << (2 * I));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else begin
        valid_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[j] <= s_in;
      if (x_in >= t) begin
        x_r[j] <= x_in - t;
        q_r[j] <= q_in | (ROOT_W'(1) << I);
      end else begin
        x_r[j] <= x_in;
        q_r[j] <= q_in;
      end
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign out_root  = q_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

>>> design/sphere_box_collision_unit.sv
// Integer 3D collision and clearance unit.
// Input channel: an item (opcode and two operands in in_item) is taken at a
// rising edge where start is high and busy is low. Busy is high only during
// reset and the cycle after it, so one item may be taken every cycle.
// Result channel: out_valid marks out_item for exactly one cycle; the
// receiver cannot hold results off, and none is needed since nothing stalls.
// Pipeline: four stages of lane arithmetic, squaring and summing, one compare
// stage, COORD_BITS + 1 square-root stages (one root bit each) and the output
// register.
// Throughput: one item per cycle, set by the fully pipelined square root.
// Reset clears every valid bit, so all items in flight are dropped and no
// result appears until a new item has passed through.
module sphere_box_collision_unit #(
  parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sbc_pkg::in_item_t   in_item,
  output logic                out_valid,
  output sbc_pkg::out_item_t  out_item
);

  localparam int C      = COORD_BITS;
  localparam int EXT_W  = (3 * C > sbc_pkg::FIELD_W) ? 3 * C : sbc_pkg::FIELD_W;
  localparam int DW     = C + 2;
  localparam int RW     = C + 1;
  localparam int SQ_W   = 2 * C + 2;
  localparam int ROOT_W = (SQ_W + 1) / 2;
  localparam int SW     = 4 + RW;
  localparam int FW     = (DW > sbc_pkg::CLEAR_W + 1) ? DW : sbc_pkg::CLEAR_W + 1;

  typedef struct packed {
    sbc_pkg::op_t  op;
    logic          hit;
    logic [RW-1:0] rad;
  } side_t;

  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Stage 1: lanes and box ends.
  logic                s1_valid_r;
  sbc_pkg::op_t        s1_op_r;
  logic signed [DW-1:0] s1_alo_r [3];
  logic signed [DW-1:0] s1_ahi_r [3];
  logic signed [DW-1:0] s1_blo_r [3];
  logic signed [DW-1:0] s1_bhi_r [3];
  logic [C-1:0]        s1_ra_r;
  logic [C-1:0]        s1_rb_r;

  logic [EXT_W-1:0] ap_ext, ae_ext, bp_ext, be_ext;
  assign ap_ext = EXT_W'(in_item.a_position);
  assign ae_ext = EXT_W'(in_item.a_extent);
  assign bp_ext = EXT_W'(in_item.b_position);
  assign be_ext = EXT_W'(in_item.b_extent);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r <= in_item.opcode;
    s1_ra_r <= ae_ext[C-1:0];
    s1_rb_r <= be_ext[C-1:0];
    for (int k = 0; k < 3; k++) begin
      s1_alo_r[k] <= DW'($signed(ap_ext[k*C +: C]));
      s1_blo_r[k] <= DW'($signed(bp_ext[k*C +: C]));
      s1_ahi_r[k] <= DW'($signed(ap_ext[k*C +: C])) + DW'($signed({1'b0, ae_ext[k*C +: C]}));
      s1_bhi_r[k] <= DW'($signed(bp_ext[k*C +: C])) + DW'($signed({1'b0, be_ext[k*C +: C]}));
    end
  end

  // Stage 2: per-axis offset chosen by the shapes involved.
  logic                 s2_valid_r;
  sbc_pkg::op_t         s2_op_r;
  logic signed [DW-1:0] s2_d_r [3];
  logic [RW-1:0]        s2_rad_r;
  logic signed [DW-1:0] s2_d_nxt [3];
  logic [RW-1:0]        s2_rad_nxt;

  always_comb begin
    logic signed [DW-1:0] pt, lo, hi, st, en, dpb, dbb;
    for (int k = 0; k < 3; k++) begin
      if (s1_op_r == sbc_pkg::OP_BALL_BOX) begin
        pt = s1_alo_r[k];
        lo = s1_blo_r[k];
        hi = s1_bhi_r[k];
      end else begin
        pt = s1_blo_r[k];
        lo = s1_alo_r[k];
        hi = s1_ahi_r[k];
      end
      if (pt < lo) begin
        dpb = pt - lo;
      end else if (pt > hi) begin
        dpb = pt - hi;
      end else begin
        dpb = '0;
      end
      st  = (s1_alo_r[k] > s1_blo_r[k]) ? s1_alo_r[k] : s1_blo_r[k];
      en  = (s1_ahi_r[k] < s1_bhi_r[k]) ? s1_ahi_r[k] : s1_bhi_r[k];
      dbb = (st > en) ? st - en : '0;
      unique case (s1_op_r)
        sbc_pkg::OP_PT_BALL, sbc_pkg::OP_BALL_BALL: s2_d_nxt[k] = s1_blo_r[k] - s1_alo_r[k];
        sbc_pkg::OP_BALL_BOX, sbc_pkg::OP_PT_BOX,
        sbc_pkg::OP_PT_BOX_DIST:                    s2_d_nxt[k] = dpb;
        sbc_pkg::OP_BOX_BOX, sbc_pkg::OP_BOX_BOX_DIST: s2_d_nxt[k] = dbb;
        default:                                    s2_d_nxt[k] = '0;
      endcase
    end
    unique case (s1_op_r)
      sbc_pkg::OP_PT_BALL, sbc_pkg::OP_BALL_BOX: s2_rad_nxt = RW'(s1_ra_r);
      sbc_pkg::OP_BALL_BALL:                    s2_rad_nxt = RW'(s1_ra_r) + RW'(s1_rb_r);
      default:                                  s2_rad_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r  <= s1_op_r;
    s2_rad_r <= s2_rad_nxt;
    for (int k = 0; k < 3; k++) begin
      s2_d_r[k] <= s2_d_nxt[k];
    end
  end

  // Stage 3: squares.
  logic                s3_valid_r;
  sbc_pkg::op_t        s3_op_r;
  logic [SQ_W-1:0]     s3_sq_r [3];
  logic [SQ_W-1:0]     s3_r2_r;
  logic [RW-1:0]       s3_rad_r;
  logic signed [2*DW-1:0] prod [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = (2*DW)'(s2_d_r[k]) * (2*DW)'(s2_d_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_op_r  <= s2_op_r;
    s3_rad_r <= s2_rad_r;
    s3_r2_r  <= SQ_W'(s2_rad_r) * SQ_W'(s2_rad_r);
    for (int k = 0; k < 3; k++) begin
      s3_sq_r[k] <= prod[k][SQ_W-1:0];
    end
  end

  // Stage 4: squared distance.
  logic            s4_valid_r;
  sbc_pkg::op_t    s4_op_r;
  logic [SQ_W-1:0] s4_sq_r;
  logic [SQ_W-1:0] s4_r2_r;
  logic [RW-1:0]   s4_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_op_r  <= s3_op_r;
    s4_rad_r <= s3_rad_r;
    s4_r2_r  <= s3_r2_r;
    s4_sq_r  <= s3_sq_r[0] + s3_sq_r[1] + s3_sq_r[2];
  end

  // Stage 5: touch test.
  logic            s5_valid_r;
  side_t           s5_side_r;
  logic [SQ_W-1:0] s5_sq_r;
  logic            s5_hit_nxt;

  always_comb begin
    unique case (s4_op_r)
      sbc_pkg::OP_PT_BALL, sbc_pkg::OP_BALL_BALL,
      sbc_pkg::OP_BALL_BOX: s5_hit_nxt = (s4_sq_r <= s4_r2_r);
      sbc_pkg::OP_PT_BOX, sbc_pkg::OP_BOX_BOX, sbc_pkg::OP_PT_BOX_DIST,
      sbc_pkg::OP_BOX_BOX_DIST: s5_hit_nxt = (s4_sq_r == '0);
      default: s5_hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_sq_r       <= s4_sq_r;
    s5_side_r.op  <= s4_op_r;
    s5_side_r.hit <= s5_hit_nxt;
    s5_side_r.rad <= s4_rad_r;
  end

  logic              rt_valid;
  logic [ROOT_W-1:0] rt_root;
  logic [SW-1:0]     rt_side_bits;
  side_t             rt_side;

  sbc_isqrt #(
    .VAL_W  (SQ_W),
    .SIDE_W (SW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_valid_r),
    .in_value  (s5_sq_r),
    .in_side   (SW'(s5_side_r)),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side_bits)
  );

  assign rt_side = side_t'(rt_side_bits);

  // Output stage: clearance less radii, clamped and saturated.
  logic                 out_valid_r;
  sbc_pkg::out_item_t   out_item_r;
  sbc_pkg::out_item_t   out_item_nxt;
  logic signed [FW-1:0] diff;

  always_comb begin
    diff = FW'($signed({1'b0, rt_root})) - FW'($signed({1'b0, rt_side.rad}));
    out_item_nxt.collided  = rt_side.hit;
    out_item_nxt.clearance = '0;
    unique case (rt_side.op)
      sbc_pkg::OP_PT_BALL, sbc_pkg::OP_BALL_BALL, sbc_pkg::OP_BALL_BOX,
      sbc_pkg::OP_PT_BOX_DIST, sbc_pkg::OP_BOX_BOX_DIST: begin
        if (rt_side.hit || diff <= 0) begin
          out_item_nxt.clearance = '0;
        end else if (diff > FW'($signed({1'b0, sbc_pkg::CLEAR_MAX}))) begin
          out_item_nxt.clearance = sbc_pkg::CLEAR_MAX;
        end else begin
          out_item_nxt.clearance = diff[sbc_pkg::CLEAR_W-1:0];
        end
      end
      default: out_item_nxt.clearance = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_hit_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.collided |-> out_item.clearance == '0)
    else $error("collided result with non-zero clearance");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && busy)
    else $error("result or ready seen straight after reset");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(start && !busy))
    else $error("pipeline entry without an accepted item");
`endif

endmodule

>>> tb/sphere_box_collision_unit_tb.sv
`timescale 1ns / 100ps

module sphere_box_collision_unit_tb;

  localparam int LANE = sbc_pkg::COORD_BITS_DEF;
  localparam int LATENCY = LANE + 6;
  localparam int CLR_MAX = 262143;

  typedef struct {
    logic [2:0]  op;
    logic [47:0] ap, ae, bp, be;
    bit          has_exp;
    bit          hit;
    int          clr;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  sbc_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  sbc_pkg::out_item_t out_item;

  sbc_pkg::out_item_t pending_q[$];
  int        errors = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        idle_pct = 0;
  int        op_count[8];

  sphere_box_collision_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint lane_s(logic [47:0] f, int k);
    logic [LANE-1:0] v;
    v = f[k*LANE +: LANE];
    return longint'($signed(v));
  endfunction

  function automatic longint lane_u(logic [47:0] f, int k);
    return longint'(f[k*LANE +: LANE]);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic int clip_clear(longint d);
    if (d <= 0) return 0;
    if (d > CLR_MAX) return CLR_MAX;
    return int'(d);
  endfunction

  function automatic longint unsigned pt_box_sq(logic [47:0] p, logic [47:0] bpos,
                                                logic [47:0] bsz);
    longint unsigned s;
    longint c, lo, hi, m;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      c = lane_s(p, k);
      lo = lane_s(bpos, k);
      hi = lo + lane_u(bsz, k);
      m = (c < lo) ? lo : ((c > hi) ? hi : c);
      s += longint'((c - m) * (c - m));
    end
    return s;
  endfunction

  function automatic longint unsigned pt_pt_sq(logic [47:0] p, logic [47:0] q);
    longint unsigned s;
    longint d;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = lane_s(p, k) - lane_s(q, k);
      s += longint'(d * d);
    end
    return s;
  endfunction

  function automatic longint unsigned box_gap_sq(logic [47:0] ap, logic [47:0] as,
                                                 logic [47:0] bp, logic [47:0] bs);
    longint unsigned s;
    longint alo, ahi, blo, bhi, st, en, g;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      alo = lane_s(ap, k);
      ahi = alo + lane_u(as, k);
      blo = lane_s(bp, k);
      bhi = blo + lane_u(bs, k);
      st = (alo > blo) ? alo : blo;
      en = (ahi < bhi) ? ahi : bhi;
      g = (st > en) ? st - en : 0;
      s += longint'(g * g);
    end
    return s;
  endfunction

  function automatic sbc_pkg::out_item_t ball_result(longint unsigned sq, longint radii);
    sbc_pkg::out_item_t r;
    r.collided = (sq <= longint'(radii * radii));
    r.clearance = r.collided ? '0 :
                  sbc_pkg::CLEAR_W'(clip_clear(root_floor(sq) - radii));
    return r;
  endfunction

  function automatic sbc_pkg::out_item_t predict_collision(sbc_pkg::in_item_t it);
    sbc_pkg::out_item_t r;
    longint unsigned sq;
    longint ra, rb;
    r = '0;
    ra = lane_u(it.a_extent, 0);
    rb = lane_u(it.b_extent, 0);
    case (it.opcode)
      sbc_pkg::OP_PT_BALL:
        r = ball_result(pt_pt_sq(it.b_position, it.a_position), ra);
      sbc_pkg::OP_BALL_BALL:
        r = ball_result(pt_pt_sq(it.a_position, it.b_position), ra + rb);
      sbc_pkg::OP_BALL_BOX:
        r = ball_result(pt_box_sq(it.a_position, it.b_position, it.b_extent), ra);
      sbc_pkg::OP_PT_BOX:
        r.collided = (pt_box_sq(it.b_position, it.a_position, it.a_extent) == 0);
      sbc_pkg::OP_BOX_BOX:
        r.collided = (box_gap_sq(it.a_position, it.a_extent, it.b_position,
                                 it.b_extent) == 0);
      sbc_pkg::OP_PT_BOX_DIST: begin
        sq = pt_box_sq(it.b_position, it.a_position, it.a_extent);
        r.collided = (sq == 0);
        r.clearance = sbc_pkg::CLEAR_W'(clip_clear(root_floor(sq)));
      end
      sbc_pkg::OP_BOX_BOX_DIST: begin
        sq = box_gap_sq(it.a_position, it.a_extent, it.b_position, it.b_extent);
        r.collided = (sq == 0);
        r.clearance = sbc_pkg::CLEAR_W'(clip_clear(root_floor(sq)));
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Drives one item and holds it until the block takes it. Start stays high
  // afterwards so that the next item can follow without a gap.
  task automatic send_query(sbc_pkg::in_item_t it, bit has_exp, sbc_pkg::out_item_t exp_val);
    sbc_pkg::out_item_t p;
    p = predict_collision(it);
    if (has_exp && p !== exp_val) begin
      $display("%0t: table row disagrees with predictor: expected %h, predicted %h",
               $time, exp_val, p);
      errors++;
    end
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_q.push_back(has_exp ? exp_val : p);
    items_sent++;
    op_count[3'(it.opcode)]++;
    @(negedge clk);
  endtask

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [47:0] rand_lanes(int span);
    logic [47:0] v;
    for (int k = 0; k < 3; k++)
      v[k*16 +: 16] = 16'($urandom_range(2 * span, 0) - span);
    return v;
  endfunction

  function automatic logic [47:0] rand_sizes(int span);
    return {16'($urandom_range(span, 0)), 16'($urandom_range(span, 0)),
            16'($urandom_range(span, 0))};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        sbc_pkg::out_item_t e;
        e = pending_q.pop_front();
        if (out_item.collided !== e.collided || out_item.clearance !== e.clearance) begin
          $display("%0t: mismatch: expected collided %0b clearance %0d, got %0b %0d",
                   $time, e.collided, e.clearance, out_item.collided, out_item.clearance);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("sphere_box_collision_unit test failed");
    $finish;
  end

  initial begin
    row_t               dir[$];
    row_t               rw;
    sbc_pkg::in_item_t  it;
    sbc_pkg::out_item_t ev;
    int                 mode, span;

    // Directed rows; the expected value is given only where it is obvious.
    dir.push_back('{3'd0, '0, '0, '0, '0, 1, 1, 0});
    dir.push_back('{3'd0, pack3(0,0,0), pack3(5,0,0), pack3(3,4,0), '0, 1, 1, 0});
    dir.push_back('{3'd0, pack3(0,0,0), pack3(4,0,0), pack3(3,4,0), '0, 1, 0, 1});
    dir.push_back('{3'd1, pack3(-32768,-32768,-32768), pack3(0,0,0),
                  pack3(32767,32767,32767), pack3(0,0,0), 1, 0, 113509});
    dir.push_back('{3'd1, pack3(10,10,10), pack3(65535,0,0), pack3(-100,50,7),
                  pack3(65535,0,0), 1, 1, 0});
    dir.push_back('{3'd2, pack3(5,5,5), pack3(0,0,0), pack3(0,0,0), pack3(10,10,10),
                  1, 1, 0});
    dir.push_back('{3'd2, pack3(20,5,5), pack3(3,0,0), pack3(0,0,0), pack3(10,10,10),
                  1, 0, 7});
    dir.push_back('{3'd3, pack3(0,0,0), pack3(10,10,10), pack3(10,10,10), '0, 1, 1, 0});
    dir.push_back('{3'd3, pack3(0,0,0), pack3(10,10,10), pack3(11,10,10), '0, 1, 0, 0});
    dir.push_back('{3'd4, pack3(0,0,0), pack3(5,5,5), pack3(5,5,5), pack3(1,1,1), 1, 1, 0});
    dir.push_back('{3'd4, pack3(0,0,0), pack3(5,5,5), pack3(6,0,0), pack3(1,1,1), 1, 0, 0});
    dir.push_back('{3'd5, pack3(0,0,0), pack3(0,0,0), pack3(3,4,0), '1, 1, 0, 5});
    dir.push_back('{3'd5, pack3(-32768,-32768,-32768), '0, pack3(32767,32767,32767), '0,
                  1, 0, 113509});
    dir.push_back('{3'd6, pack3(0,0,0), pack3(2,2,2), pack3(5,2,2), pack3(1,1,1), 1, 0, 3});
    dir.push_back('{3'd6, pack3(-32768,0,0), '1, pack3(32767,32767,32767), '1, 1, 1, 0});
    dir.push_back('{3'd7, '1, '1, '1, '1, 1, 0, 0});
    dir.push_back('{3'd7, '0, '0, '0, '0, 1, 0, 0});
    dir.push_back('{3'd1, '1, '1, '0, '0, 0, 0, 0});
    dir.push_back('{3'd2, 48'h8000_7fff_1234, 48'hffff_ffff_ffff, '1, '1, 0, 0, 0});
    dir.push_back('{3'd0, 48'h7fff_8000_0001, '0, 48'h8000_7fff_ffff, '1, 0, 0, 0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir[i]) begin
      rw = dir[i];
      it.opcode = sbc_pkg::op_t'(rw.op);
      it.a_position = rw.ap;
      it.a_extent = rw.ae;
      it.b_position = rw.bp;
      it.b_extent = rw.be;
      ev.collided = rw.hit;
      ev.clearance = sbc_pkg::CLEAR_W'(rw.clr);
      send_query(it, rw.has_exp, ev);
    end

    // Hold off until the pipeline has drained before random traffic.
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);

    for (int n = 0; n < 1150; n++) begin
      case ((n / 150) % 4)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 0;
        default: idle_pct = 17;
      endcase
      if (n == 600) begin
        start <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
      end
      mode = $urandom_range(9, 0);
      // Mostly nearby shapes so that hits and near misses are both common.
      span = (mode < 6) ? 64 : ((mode < 9) ? 4000 : 32768);
      it.opcode = sbc_pkg::op_t'($urandom_range(7, 0));
      if (mode == 9) begin
        it.a_position = 48'({$urandom, $urandom});
        it.a_extent = 48'({$urandom, $urandom});
        it.b_position = 48'({$urandom, $urandom});
        it.b_extent = 48'({$urandom, $urandom});
      end else begin
        it.a_position = rand_lanes(span);
        it.b_position = rand_lanes(span);
        it.a_extent = rand_sizes(span / 2);
        it.b_extent = rand_sizes(span / 2);
        if ($urandom_range(3, 0) == 0) it.a_extent[47:16] = {$urandom};
      end
      send_query(it, 0, '0);
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);

    $display("Sent %0d queries over all eight opcodes (%0d unused-opcode) and checked %0d results,",
             items_sent, op_count[7], results_seen);
    $display("with sender gaps of 0, 17 and 45 percent.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("sphere_box_collision_unit test passed");
    end else begin
      $display("sphere_box_collision_unit test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sbc_pkg.sv
design/sbc_isqrt.sv
design/sphere_box_collision_unit.sv
tb/sphere_box_collision_unit_tb.sv
